[rtl/lrpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpe_pkg
// Shared codes and sizes of the LR parse engine.
// ----------------------------------------------------------------------------
package lrpe_pkg;

    localparam int STATE_COUNT       = 256;
    localparam int TERMINAL_COUNT    = 64;
    localparam int NONTERMINAL_COUNT = 64;
    localparam int PRODUCTION_COUNT  = 256;
    localparam int STACK_DEPTH       = 64;
    localparam int MAX_RHS           = 15;
    localparam int RESULT_LIMIT      = 64;

    localparam logic [2:0] OP_TOKEN   = 3'd0;
    localparam logic [2:0] OP_ACTION  = 3'd1;
    localparam logic [2:0] OP_GOTO    = 3'd2;
    localparam logic [2:0] OP_PROD    = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    localparam logic [1:0] KIND_ERROR  = 2'd0;
    localparam logic [1:0] KIND_SHIFT  = 2'd1;
    localparam logic [1:0] KIND_REDUCE = 2'd2;
    localparam logic [1:0] KIND_ACCEPT = 2'd3;

    localparam logic [2:0] EV_SHIFT  = 3'd0;
    localparam logic [2:0] EV_REDUCE = 3'd1;
    localparam logic [2:0] EV_ACCEPT = 3'd2;
    localparam logic [2:0] EV_SYNTAX = 3'd3;
    localparam logic [2:0] EV_NOGOTO = 3'd4;
    localparam logic [2:0] EV_STACK  = 3'd5;
    localparam logic [2:0] EV_WRITE  = 3'd6;

endpackage

[rtl/lrpe_table_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpe_table_ram
// One write port, one registered read port; holds action/goto/production.
// ----------------------------------------------------------------------------
module lrpe_table_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/lr_shift_reduce_parse_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_shift_reduce_parse_engine
// Table-driven LR parser: load tables, feed tokens, collect parse events.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the action and goto tables to clear them, one
// entry per cycle; no request is taken until that finishes. Table writes and
// restart go through the output state and give one write-done event. A token
// steps through accept, action read, evaluate and output for its action
// lookup, and each reduce adds action read and evaluate, production read and
// evaluate, stack read below the popped entries, goto read and evaluate, and
// output; the loop through the action, production and goto memories, each
// with a registered read, sets those steps. One request is in flight at a
// time; a finished event sits in the output register while the next step of
// the same token waits for it to be taken, and a new request is not taken
// while an event is stalled there. The state stack lives in a memory too,
// with its top cached in a register so that the action lookup needs no stack
// read. Errors and accept return the stack to state 0.
// ----------------------------------------------------------------------------
module lr_shift_reduce_parse_engine #(
    parameter int STATE_COUNT       = lrpe_pkg::STATE_COUNT,
    parameter int TERMINAL_COUNT    = lrpe_pkg::TERMINAL_COUNT,
    parameter int NONTERMINAL_COUNT = lrpe_pkg::NONTERMINAL_COUNT,
    parameter int PRODUCTION_COUNT  = lrpe_pkg::PRODUCTION_COUNT,
    parameter int STACK_DEPTH       = lrpe_pkg::STACK_DEPTH,
    parameter int MAX_RHS           = lrpe_pkg::MAX_RHS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic [5:0] token_kind,
    input  logic [7:0] row_state,
    input  logic [5:0] nonterminal,
    input  logic [1:0] action_kind,
    input  logic [7:0] target,
    input  logic [3:0] rhs_length,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] event_state,
    output logic [7:0] production,
    output logic [5:0] symbol,
    output logic [3:0] children,
    output logic       last
);

    localparam int SW  = $clog2(STATE_COUNT);
    localparam int TW  = $clog2(TERMINAL_COUNT);
    localparam int NW  = $clog2(NONTERMINAL_COUNT);
    localparam int PW  = $clog2(PRODUCTION_COUNT);
    localparam int KW  = $clog2(STACK_DEPTH);
    localparam int AD  = STATE_COUNT * TERMINAL_COUNT;
    localparam int GD  = STATE_COUNT * NONTERMINAL_COUNT;
    localparam int AAW = $clog2(AD);
    localparam int GAW = $clog2(GD);
    localparam int CD  = (AD > GD) ? AD : GD;
    localparam int CW  = $clog2(CD) + 1;
    localparam int TOPW = $clog2(STACK_DEPTH + 1);
    localparam logic [3:0] RHS_SAT = (MAX_RHS > 15) ? 4'd15 : 4'(MAX_RHS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACT_RD, S_ACT_EVAL, S_PROD_RD, S_PROD_EVAL,
        S_STK_RD, S_GOTO_RD, S_GOTO_EVAL, S_OUT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     clr_reg;
    logic [TOPW-1:0]   top_reg;       // entries on stack
    logic [7:0]        tos_reg;       // cached top state
    logic [5:0]        tok_reg;
    logic [6:0]        cnt_reg;       // reduce events given for this token
    logic [7:0]        prod_reg;
    logic [5:0]        left_reg;
    logic [3:0]        len_reg;
    logic              cont_reg;      // another step follows the output

    // output register
    logic       ov_reg;
    logic [2:0] ev_reg;
    logic [7:0] es_reg;
    logic [7:0] pr_reg;
    logic [5:0] sy_reg;
    logic [3:0] ch_reg;
    logic       la_reg;

    // memories
    logic             a_we, g_we, p_we;
    logic [AAW-1:0]   a_wa, a_ra;
    logic [GAW-1:0]   g_wa, g_ra;
    logic [PW-1:0]    p_wa, p_ra;
    logic [9:0]       a_wd, a_rd;
    logic [8:0]       g_wd, g_rd;
    logic [9:0]       p_wd, p_rd;
    logic [7:0]       stk [STACK_DEPTH];
    logic [7:0]       stk_rd;
    logic             stk_we;
    logic [KW-1:0]    stk_wa, stk_ra;
    logic [7:0]       stk_wd;

    logic acc;
    assign acc = in_valid && in_ready;
    // a write request loads the output register at once, so hold off while
    // an event is stalled there
    assign in_ready = (state_reg == S_IDLE) && !(ov_reg && !out_ready);

    assign out_valid   = ov_reg;
    assign event_res   = ev_reg;
    assign event_state = es_reg;
    assign production  = pr_reg;
    assign symbol      = sy_reg;
    assign children    = ch_reg;
    assign last        = la_reg;

    // lookup range checks
    logic act_in, goto_in, prod_in;
    assign act_in  = (32'(tos_reg) < STATE_COUNT) && (32'(tok_reg) < TERMINAL_COUNT);
    assign prod_in = 32'(prod_reg) < PRODUCTION_COUNT;
    assign goto_in = (32'(stk_rd) < STATE_COUNT) && (32'(left_reg) < NONTERMINAL_COUNT);

    always_comb
    begin
        a_we = 1'b0; a_wa = '0; a_wd = '0;
        g_we = 1'b0; g_wa = '0; g_wd = '0;
        p_we = 1'b0;
        p_wa = PW'(target);
        p_wd = {((rhs_length > RHS_SAT) ? RHS_SAT : rhs_length), nonterminal};
        if (state_reg == S_CLEAR)
        begin
            a_we = clr_reg < CW'(AD);
            g_we = clr_reg < CW'(GD);
            a_wa = AAW'(clr_reg);
            g_wa = GAW'(clr_reg);
        end
        else if (acc)
        begin
            a_we = (operation == lrpe_pkg::OP_ACTION) && (32'(row_state) < STATE_COUNT)
                   && (32'(token_kind) < TERMINAL_COUNT);
            a_wa = AAW'(32'(row_state) * TERMINAL_COUNT + 32'(token_kind));
            a_wd = {action_kind, target};
            g_we = (operation == lrpe_pkg::OP_GOTO) && (32'(row_state) < STATE_COUNT)
                   && (32'(nonterminal) < NONTERMINAL_COUNT);
            g_wa = GAW'(32'(row_state) * NONTERMINAL_COUNT + 32'(nonterminal));
            g_wd = {1'b1, target};
            p_we = (operation == lrpe_pkg::OP_PROD) && (32'(target) < PRODUCTION_COUNT);
        end
        a_ra = AAW'(32'(tos_reg) * TERMINAL_COUNT + 32'(tok_reg));
        g_ra = GAW'(32'(stk_rd) * NONTERMINAL_COUNT + 32'(left_reg));
        p_ra = PW'(prod_reg);
    end

    lrpe_table_ram #(.DEPTH(AD), .WIDTH(10)) u_action (
        .clk(clk), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
        .rd_addr(a_ra), .rd_data(a_rd)
    );
    lrpe_table_ram #(.DEPTH(GD), .WIDTH(9)) u_goto (
        .clk(clk), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
        .rd_addr(g_ra), .rd_data(g_rd)
    );
    lrpe_table_ram #(.DEPTH(PRODUCTION_COUNT), .WIDTH(10)) u_prod (
        .clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
        .rd_addr(p_ra), .rd_data(p_rd)
    );

    // state stack memory; read address is the entry below the popped ones
    logic [TOPW-1:0] pop_top;
    assign pop_top = top_reg - TOPW'(len_reg);
    assign stk_ra  = KW'(pop_top - TOPW'(1));

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk[stk_wa] <= stk_wd;
        end
        stk_rd <= stk[stk_ra];
    end

    // decoded action / production
    logic [1:0] a_kind;
    logic [7:0] a_tgt;
    assign a_kind = act_in ? a_rd[9:8] : lrpe_pkg::KIND_ERROR;
    assign a_tgt  = a_rd[7:0];
    logic [3:0] p_len;
    logic [5:0] p_left;
    assign p_len  = prod_in ? p_rd[9:6] : 4'd0;
    assign p_left = prod_in ? p_rd[5:0] : 6'd0;
    logic g_ok;
    assign g_ok = goto_in && g_rd[8];

    logic full;
    assign full = 32'(top_reg) >= STACK_DEPTH;

    always_comb
    begin
        stk_we = 1'b0;
        stk_wa = KW'(top_reg);
        stk_wd = a_tgt;
        if (state_reg == S_CLEAR)
        begin
            // bottom entry holds state 0
            stk_we = 1'b1;
            stk_wa = '0;
            stk_wd = '0;
        end
        if (state_reg == S_ACT_EVAL && a_kind == lrpe_pkg::KIND_SHIFT && !full
            && !(ov_reg && !out_ready))
        begin
            stk_we = 1'b1;
        end
        if (state_reg == S_GOTO_EVAL && g_ok && !(32'(pop_top) >= STACK_DEPTH)
            && !(ov_reg && !out_ready))
        begin
            stk_we = 1'b1;
            stk_wa = KW'(pop_top);
            stk_wd = g_rd[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            top_reg   <= TOPW'(1);
            tos_reg   <= '0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            cont_reg  <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready && state_reg != S_OUT)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == CW'(CD - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (acc)
                    begin
                        tok_reg <= token_kind;
                        cnt_reg <= '0;
                        if (operation == lrpe_pkg::OP_TOKEN)
                        begin
                            state_reg <= S_ACT_RD;
                        end
                        else if (operation <= lrpe_pkg::OP_RESTART)
                        begin
                            if (operation == lrpe_pkg::OP_RESTART)
                            begin
                                top_reg <= TOPW'(1);
                                tos_reg <= '0;
                            end
                            ev_reg <= lrpe_pkg::EV_WRITE;
                            es_reg <= '0; pr_reg <= '0; sy_reg <= '0;
                            ch_reg <= '0; la_reg <= 1'b1;
                            cont_reg  <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_ACT_RD:
                begin
                    state_reg <= S_ACT_EVAL;
                end
                S_ACT_EVAL:
                begin
                    if (!(ov_reg && !out_ready))
                    begin
                        pr_reg <= '0; sy_reg <= tok_reg; ch_reg <= '0; la_reg <= 1'b1;
                        es_reg <= tos_reg;
                        cont_reg  <= 1'b0;
                        state_reg <= S_OUT;
                        case (a_kind)
                            lrpe_pkg::KIND_SHIFT:
                            begin
                                if (full)
                                begin
                                    ev_reg <= lrpe_pkg::EV_STACK;
                                    top_reg <= TOPW'(1); tos_reg <= '0;
                                end
                                else
                                begin
                                    ev_reg <= lrpe_pkg::EV_SHIFT;
                                    es_reg <= a_tgt;
                                    top_reg <= top_reg + TOPW'(1);
                                    tos_reg <= a_tgt;
                                end
                            end
                            lrpe_pkg::KIND_REDUCE:
                            begin
                                if (32'(cnt_reg) >= lrpe_pkg::RESULT_LIMIT - 1)
                                begin
                                    ev_reg <= lrpe_pkg::EV_STACK;
                                    sy_reg <= '0;
                                    top_reg <= TOPW'(1); tos_reg <= '0;
                                end
                                else
                                begin
                                    prod_reg  <= a_tgt;
                                    state_reg <= S_PROD_RD;
                                end
                            end
                            lrpe_pkg::KIND_ACCEPT:
                            begin
                                ev_reg <= lrpe_pkg::EV_ACCEPT;
                                sy_reg <= '0;
                                top_reg <= TOPW'(1); tos_reg <= '0;
                            end
                            default:
                            begin
                                ev_reg <= lrpe_pkg::EV_SYNTAX;
                                top_reg <= TOPW'(1); tos_reg <= '0;
                            end
                        endcase
                    end
                end
                S_PROD_RD:
                begin
                    state_reg <= S_PROD_EVAL;
                end
                S_PROD_EVAL:
                begin
                    len_reg  <= p_len;
                    left_reg <= p_left;
                    if (TOPW'(p_len) > top_reg - TOPW'(1))
                    begin
                        if (!(ov_reg && !out_ready))
                        begin
                            ev_reg <= lrpe_pkg::EV_STACK;
                            es_reg <= tos_reg; pr_reg <= prod_reg; sy_reg <= p_left;
                            ch_reg <= p_len; la_reg <= 1'b1;
                            top_reg <= TOPW'(1); tos_reg <= '0;
                            cont_reg  <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        state_reg <= S_STK_RD;
                    end
                end
                S_STK_RD:
                begin
                    state_reg <= S_GOTO_RD;
                end
                S_GOTO_RD:
                begin
                    state_reg <= S_GOTO_EVAL;
                end
                S_GOTO_EVAL:
                begin
                    if (!(ov_reg && !out_ready))
                    begin
                        pr_reg <= prod_reg; sy_reg <= left_reg; ch_reg <= len_reg;
                        es_reg <= stk_rd; la_reg <= 1'b1;
                        cont_reg  <= 1'b0;
                        state_reg <= S_OUT;
                        if (!g_ok)
                        begin
                            ev_reg <= lrpe_pkg::EV_NOGOTO;
                            top_reg <= TOPW'(1); tos_reg <= '0;
                        end
                        else if (32'(pop_top) >= STACK_DEPTH)
                        begin
                            ev_reg <= lrpe_pkg::EV_STACK;
                            top_reg <= TOPW'(1); tos_reg <= '0;
                        end
                        else
                        begin
                            ev_reg <= lrpe_pkg::EV_REDUCE;
                            es_reg <= g_rd[7:0];
                            la_reg <= 1'b0;
                            top_reg <= pop_top + TOPW'(1);
                            tos_reg <= g_rd[7:0];
                            cnt_reg <= cnt_reg + 7'd1;
                            cont_reg <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    // mark the output register valid, then take the next step or go idle
                    ov_reg    <= 1'b1;
                    state_reg <= cont_reg ? S_ACT_RD : S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/lrpe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpe_checker
// Port-level checks of the parse engine, bound to the top level.
// ----------------------------------------------------------------------------
module lrpe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_res,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res))
        else $error("result dropped while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= lrpe_pkg::EV_WRITE)
        else $error("bad event code");

    a_reduce_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == lrpe_pkg::EV_REDUCE |-> !last)
        else $error("reduce marked last");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != lrpe_pkg::EV_REDUCE |-> last)
        else $error("terminal event not last");

    a_busy_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while event stalled");

endmodule

bind lr_shift_reduce_parse_engine lrpe_checker u_lrpe_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
    .last(last)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LR shift-reduce parse engine.
// ----------------------------------------------------------------------------
// Loads action, goto and production tables, feeds tokens and compares every
// parse event against a local model of the parser tables and state stack.
// A directed part covers accept, syntax error, missing goto, underflow,
// overflow, the result limit, restart and unused opcodes. A random part then
// mixes table writes and tokens over a small grammar so that reduce chains
// and stack growth are common. Both handshakes idle at random, and the event
// side holds off once for a long stretch to back the engine up.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] tok;
        logic [7:0] row;
        logic [5:0] nt;
        logic [1:0] kind;
        logic [7:0] tgt;
        logic [3:0] len;
    } request_t;

    typedef struct packed {
        logic [2:0] res;
        logic [7:0] st;
        logic [7:0] prod;
        logic [5:0] sym;
        logic [3:0] ch;
        logic       last;
    } parse_event_t;

    // ------------------------------------------------------------------------
    // Parser model and event scoreboard
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        // kind, target
        bit [9:0]     action_mem [lrpe_pkg::STATE_COUNT*lrpe_pkg::TERMINAL_COUNT];
        // valid, state
        bit [8:0]     goto_mem   [lrpe_pkg::STATE_COUNT*lrpe_pkg::NONTERMINAL_COUNT];
        bit [9:0]     prod_mem   [lrpe_pkg::PRODUCTION_COUNT];   // length, left
        bit [7:0]     state_stack [lrpe_pkg::STACK_DEPTH];
        int           depth = 1;
        parse_event_t expected_events [$];
        int           mismatches = 0;

        function void add(logic [2:0] res, logic [7:0] st, logic [7:0] prod,
                          logic [5:0] sym, logic [3:0] ch, logic lst);
            parse_event_t e;
            e.res = res; e.st = st; e.prod = prod; e.sym = sym; e.ch = ch;
            e.last = lst;
            expected_events = {expected_events, e};
        endfunction

        function void parse_token(logic [5:0] tok);
            int       n;
            bit [7:0] top, tgt, nxt;
            bit [1:0] kind;
            bit [3:0] len;
            bit [5:0] left;
            bit [8:0] g;
            n = 0;
            forever begin
                top  = state_stack[depth-1];
                kind = action_mem[top*lrpe_pkg::TERMINAL_COUNT + tok][9:8];
                tgt  = action_mem[top*lrpe_pkg::TERMINAL_COUNT + tok][7:0];
                if (kind == lrpe_pkg::KIND_REDUCE) begin
                    if (n >= lrpe_pkg::RESULT_LIMIT - 1) begin
                        add(lrpe_pkg::EV_STACK, top, 0, 0, 0, 1);
                        depth = 1; state_stack[0] = 0; return;
                    end
                    len  = prod_mem[tgt][9:6];
                    left = prod_mem[tgt][5:0];
                    if (len > depth - 1) begin
                        add(lrpe_pkg::EV_STACK, top, tgt, left, len, 1);
                        depth = 1; state_stack[0] = 0; return;
                    end
                    depth = depth - len;
                    nxt = state_stack[depth-1];
                    g = goto_mem[nxt*lrpe_pkg::NONTERMINAL_COUNT + left];
                    if (!g[8]) begin
                        add(lrpe_pkg::EV_NOGOTO, nxt, tgt, left, len, 1);
                        depth = 1; state_stack[0] = 0; return;
                    end
                    if (depth >= lrpe_pkg::STACK_DEPTH) begin
                        add(lrpe_pkg::EV_STACK, nxt, tgt, left, len, 1);
                        depth = 1; state_stack[0] = 0; return;
                    end
                    state_stack[depth] = g[7:0];
                    depth++;
                    add(lrpe_pkg::EV_REDUCE, g[7:0], tgt, left, len, 0);
                    n++;
                end else if (kind == lrpe_pkg::KIND_SHIFT) begin
                    if (depth >= lrpe_pkg::STACK_DEPTH) begin
                        add(lrpe_pkg::EV_STACK, top, 0, tok, 0, 1);
                        depth = 1; state_stack[0] = 0; return;
                    end
                    state_stack[depth] = tgt;
                    depth++;
                    add(lrpe_pkg::EV_SHIFT, tgt, 0, tok, 0, 1);
                    return;
                end else begin
                    // accept and syntax error both drop back to state 0
                    if (kind == lrpe_pkg::KIND_ACCEPT)
                        add(lrpe_pkg::EV_ACCEPT, top, 0, 0, 0, 1);
                    else
                        add(lrpe_pkg::EV_SYNTAX, top, 0, tok, 0, 1);
                    depth = 1; state_stack[0] = 0; return;
                end
            end
        endfunction

        function void note_request(request_t r);
            case (r.op)
                lrpe_pkg::OP_TOKEN:   begin parse_token(r.tok); return; end
                lrpe_pkg::OP_ACTION:
                    action_mem[r.row*lrpe_pkg::TERMINAL_COUNT + r.tok] = {r.kind, r.tgt};
                lrpe_pkg::OP_GOTO:
                    goto_mem[r.row*lrpe_pkg::NONTERMINAL_COUNT + r.nt] = {1'b1, r.tgt};
                lrpe_pkg::OP_PROD:    prod_mem[r.tgt] = {r.len, r.nt};
                lrpe_pkg::OP_RESTART: begin depth = 1; state_stack[0] = 0; end
                default:    return;  // unused opcodes are dropped silently
            endcase
            add(lrpe_pkg::EV_WRITE, 0, 0, 0, 0, 1);
        endfunction

        function void check_event(parse_event_t got);
            parse_event_t exp;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event res=%0d st=%0d prod=%0d sym=%0d ch=%0d last=%0d",
                             got.res, got.st, got.prod, got.sym, got.ch, got.last);
                return;
            end
            exp = expected_events.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"event mismatch exp res=%0d st=%0d prod=%0d sym=%0d ",
                              "ch=%0d last=%0d got res=%0d st=%0d prod=%0d sym=%0d ",
                              "ch=%0d last=%0d"},
                             exp.res, exp.st, exp.prod, exp.sym, exp.ch, exp.last,
                             got.res, got.st, got.prod, got.sym, got.ch, got.last);
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [2:0] operation = 0;
    logic [5:0] token_kind = 0;
    logic [7:0] row_state = 0;
    logic [5:0] nonterminal = 0;
    logic [1:0] action_kind = 0;
    logic [7:0] target = 0;
    logic [3:0] rhs_length = 0;
    logic       out_valid;
    logic       out_ready = 0;
    logic [2:0] event_res;
    logic [7:0] event_state;
    logic [7:0] production;
    logic [5:0] symbol;
    logic [3:0] children;
    logic       last;

    parse_scoreboard sb = new();
    int              events_seen = 0;
    // reduces only use loaded rules
    bit              prod_loaded [lrpe_pkg::PRODUCTION_COUNT];

    lr_shift_reduce_parse_engine dut (.*);

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Idle lengths: mostly short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one request and hold it until taken; the model sees it at
    // the accepting edge.
    task automatic send_request(request_t r);
        in_valid    <= 1'b1;
        operation   <= r.op;
        token_kind  <= r.tok;
        row_state   <= r.row;
        nonterminal <= r.nt;
        action_kind <= r.kind;
        target      <= r.tgt;
        rhs_length  <= r.len;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r);
        if (r.op == lrpe_pkg::OP_PROD) prod_loaded[r.tgt] = 1'b1;
        // half the time the next request follows back to back
        if ($urandom_range(0, 1)) begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic [2:0] op, logic [5:0] tok, logic [7:0] row,
                               logic [5:0] nt, logic [1:0] kind, logic [7:0] tgt,
                               logic [3:0] len);
        request_t r;
        r = '{op, tok, row, nt, kind, tgt, len};
        send_request(r);
    endtask

    // Random request over a small grammar; a few use full field ranges.
    task automatic send_random();
        request_t r;
        int       pick;
        bit       wide;
        wide = ($urandom_range(0, 9) == 0);
        r.op   = lrpe_pkg::OP_TOKEN;
        r.tok  = wide ? 6'($urandom) : 6'($urandom_range(0, 7));
        r.row  = wide ? 8'($urandom) : 8'($urandom_range(0, 15));
        r.nt   = wide ? 6'($urandom) : 6'($urandom_range(0, 3));
        r.kind = 2'($urandom);
        r.tgt  = wide ? 8'($urandom) : 8'($urandom_range(0, 15));
        r.len  = wide ? 4'($urandom) : 4'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 10)      r.op = lrpe_pkg::OP_ACTION;
        else if (pick < 18) r.op = lrpe_pkg::OP_GOTO;
        else if (pick < 24) r.op = lrpe_pkg::OP_PROD;
        else if (pick < 27) r.op = lrpe_pkg::OP_RESTART;
        else if (pick < 29) r.op = 3'($urandom_range(5, 7));
        // never reduce by a rule that has not been loaded
        if (r.op == lrpe_pkg::OP_ACTION && r.kind == lrpe_pkg::KIND_REDUCE
            && !prod_loaded[r.tgt]) begin
            r.tgt = 8'($urandom_range(0, 15));
            if (!prod_loaded[r.tgt])
                send_fields(lrpe_pkg::OP_PROD, 0, 0, r.nt, 0, r.tgt, r.len);
        end
        send_request(r);
    endtask

    // Event side: random stalls, plus one long hold-off once traffic is going.
    initial begin
        bit held;
        held = 0;
        forever begin
            if (!held && events_seen >= 100) begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                held = 1;
            end
            out_ready <= ($urandom_range(0, 9) < 7);
            repeat (idle_len()) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        parse_event_t got;
        if (out_valid && out_ready) begin
            got = '{event_res, event_state, production, symbol, children, last};
            sb.check_event(got);
            events_seen++;
        end
    end

    initial begin
        int waited;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rules:
        //   rule 1: E5 -> x (one symbol), rule 2: 15 symbols, left 63,
        //   rule 255: empty rule into nonterminal 0 (no goto -> missing goto),
        //   rule 3: empty rule that keeps pushing (stack overflow),
        //   rule 4: one-symbol rule that loops forever (event limit).
        send_fields(lrpe_pkg::OP_PROD, 0, 0, 5, 0, 1, 1);
        send_fields(lrpe_pkg::OP_PROD, 0, 0, 63, 0, 2, 15);
        send_fields(lrpe_pkg::OP_PROD, 0, 0, 0, 0, 255, 0);
        send_fields(lrpe_pkg::OP_PROD, 0, 0, 6, 0, 3, 0);
        send_fields(lrpe_pkg::OP_PROD, 0, 0, 7, 0, 4, 1);
        send_fields(lrpe_pkg::OP_ACTION, 1, 0, 0, lrpe_pkg::KIND_SHIFT, 10, 0);
        send_fields(lrpe_pkg::OP_ACTION, 2, 10, 0, lrpe_pkg::KIND_REDUCE, 1, 0);
        send_fields(lrpe_pkg::OP_GOTO, 0, 0, 5, 0, 20, 0);
        send_fields(lrpe_pkg::OP_ACTION, 2, 20, 0, lrpe_pkg::KIND_ACCEPT, 0, 0);
        send_fields(lrpe_pkg::OP_TOKEN, 1, 0, 0, 0, 0, 0);    // shift
        send_fields(lrpe_pkg::OP_TOKEN, 2, 0, 0, 0, 0, 0);    // reduce then accept
        send_fields(lrpe_pkg::OP_ACTION, 3, 0, 0, lrpe_pkg::KIND_REDUCE, 2, 0);
        send_fields(lrpe_pkg::OP_TOKEN, 3, 0, 0, 0, 0, 0);    // pop below bottom
        send_fields(lrpe_pkg::OP_ACTION, 4, 0, 0, lrpe_pkg::KIND_REDUCE, 255, 0);
        send_fields(lrpe_pkg::OP_TOKEN, 4, 0, 0, 0, 0, 0);    // missing goto
        send_fields(lrpe_pkg::OP_TOKEN, 63, 0, 0, 0, 0, 0);   // syntax error
        send_fields(lrpe_pkg::OP_ACTION, 5, 0, 0, lrpe_pkg::KIND_SHIFT, 40, 0);
        send_fields(lrpe_pkg::OP_ACTION, 6, 40, 0, lrpe_pkg::KIND_REDUCE, 3, 0);
        send_fields(lrpe_pkg::OP_GOTO, 0, 40, 6, 0, 40, 0);
        send_fields(lrpe_pkg::OP_TOKEN, 5, 0, 0, 0, 0, 0);
        send_fields(lrpe_pkg::OP_TOKEN, 6, 0, 0, 0, 0, 0);    // pushes until overflow
        send_fields(lrpe_pkg::OP_ACTION, 8, 0, 0, lrpe_pkg::KIND_SHIFT, 50, 0);
        send_fields(lrpe_pkg::OP_ACTION, 7, 50, 0, lrpe_pkg::KIND_REDUCE, 4, 0);
        send_fields(lrpe_pkg::OP_GOTO, 0, 0, 7, 0, 50, 0);
        send_fields(lrpe_pkg::OP_TOKEN, 8, 0, 0, 0, 0, 0);
        send_fields(lrpe_pkg::OP_TOKEN, 7, 0, 0, 0, 0, 0);    // hits the event limit
        send_fields(lrpe_pkg::OP_TOKEN, 1, 0, 0, 0, 0, 0);
        send_fields(lrpe_pkg::OP_RESTART, 63, 255, 63, 3, 255, 15);
        send_fields(3'd7, 63, 255, 63, 3, 255, 15);  // unused opcode, no event

        repeat (290) send_random();
        in_valid <= 1'b0;

        waited = 0;
        while (sb.expected_events.size() != 0 && waited < 200000) begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_events.size() == 0)
            $display("PASS lr_shift_reduce_parse_engine");
        else
            $display("FAIL lr_shift_reduce_parse_engine");
        $finish;
    end

    // Table clear after reset plus worst-case event chains under stalls.
    initial begin
        #20ms;
        $display("FAIL lr_shift_reduce_parse_engine");
        $finish;
    end

endmodule

[sim.f]
rtl/lrpe_pkg.sv
rtl/lrpe_table_ram.sv
rtl/lr_shift_reduce_parse_engine.sv
rtl/lrpe_checker.sv
tb/tb.sv
